[rtl/sc2c_pkg.sv]
// shared types, constants and the layout rom for the scan code decoder
`default_nettype none

package sc2c_pkg;

    // input transfer payload
    typedef struct packed {
        logic       req_type;
        logic [7:0] scan_code;
    } t_req;

    // result transfer payload
    typedef struct packed {
        logic [7:0] read_char;
        logic       fifo_was_empty;
    } t_res;

    // decoder outcome for one scan code
    typedef struct packed {
        logic       push;
        logic       shift_set;
        logic       shift_clr;
        logic [7:0] ch;
    } t_dec;

    // request kinds
    localparam logic REQ_SCAN = 1'b0;
    localparam logic REQ_READ = 1'b1;

    // character constants
    localparam logic [7:0] SHIFT_MARK = 8'd15;
    localparam logic [7:0] LOWER_A    = 8'd97;
    localparam logic [7:0] LOWER_Z    = 8'd122;
    localparam logic [7:0] CASE_GAP   = 8'd32;
    localparam logic [7:0] PRINT_MIN  = 8'd32;
    localparam logic [7:0] CH_NL      = 8'd10;
    localparam logic [7:0] CH_BS      = 8'd8;

    // german set-1 layout, latin-1 for non-ascii keys, unused keys read zero
    function automatic logic [7:0] key_rom(input logic [6:0] addr);
        logic [7:0] ch;
        unique case (addr)
            7'h02: ch = "1";
            7'h03: ch = "2";
            7'h04: ch = "3";
            7'h05: ch = "4";
            7'h06: ch = "5";
            7'h07: ch = "6";
            7'h08: ch = "7";
            7'h09: ch = "8";
            7'h0A: ch = "9";
            7'h0B: ch = "0";
            7'h0C: ch = 8'hDF;
            7'h0D: ch = 8'hB4;
            7'h0E: ch = 8'd8;
            7'h0F: ch = 8'd9;
            7'h10: ch = "q";
            7'h11: ch = "w";
            7'h12: ch = "e";
            7'h13: ch = "r";
            7'h14: ch = "t";
            7'h15: ch = "z";
            7'h16: ch = "u";
            7'h17: ch = "i";
            7'h18: ch = "o";
            7'h19: ch = "p";
            7'h1A: ch = 8'hFC;
            7'h1B: ch = "+";
            7'h1C: ch = 8'd10;
            7'h1E: ch = "a";
            7'h1F: ch = "s";
            7'h20: ch = "d";
            7'h21: ch = "f";
            7'h22: ch = "g";
            7'h23: ch = "h";
            7'h24: ch = "j";
            7'h25: ch = "k";
            7'h26: ch = "l";
            7'h27: ch = 8'hF6;
            7'h28: ch = 8'hE4;
            7'h29: ch = "^";
            7'h2A: ch = SHIFT_MARK;
            7'h2B: ch = "#";
            7'h2C: ch = "y";
            7'h2D: ch = "x";
            7'h2E: ch = "c";
            7'h2F: ch = "v";
            7'h30: ch = "b";
            7'h31: ch = "n";
            7'h32: ch = "m";
            7'h33: ch = ",";
            7'h34: ch = ".";
            7'h35: ch = "-";
            7'h36: ch = SHIFT_MARK;
            7'h39: ch = " ";
            default: ch = 8'd0;
        endcase
        return ch;
    endfunction

endpackage

`default_nettype wire

[rtl/sc2c_ram.sv]
// generic single write port ram with registered read
`default_nettype none

module sc2c_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 128
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic                     i_re,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // write port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // registered read port
    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

`default_nettype wire

[rtl/sc2c_decode.sv]
// scan code to character decode: layout lookup, shift tracking, filter
`default_nettype none

module sc2c_decode
    import sc2c_pkg::*;
(
    input  wire logic [7:0] i_scan_code,
    input  wire logic       i_shift_held,
    output t_dec            o_dec
);

    logic       is_release;
    logic [7:0] raw_ch;
    logic       is_shift;
    logic       shift_now;
    logic [7:0] ch;
    logic       passes;

    // release codes look up the key with the top bit stripped
    assign is_release = i_scan_code[7];
    assign raw_ch     = key_rom(i_scan_code[6:0]);
    assign is_shift   = (raw_ch == SHIFT_MARK);

    // press of a shift key takes effect before the case fold
    assign shift_now = i_shift_held | is_shift;

    // upper case for letters while shift is held
    always_comb begin
        ch = raw_ch;
        if (shift_now && raw_ch >= LOWER_A && raw_ch <= LOWER_Z) begin
            ch = raw_ch - CASE_GAP;
        end
    end

    // control characters are dropped except newline and backspace
    assign passes = (ch >= PRINT_MIN) || (ch == CH_NL) || (ch == CH_BS);

    assign o_dec.push      = !is_release && passes;
    assign o_dec.shift_set = !is_release && is_shift;
    assign o_dec.shift_clr = is_release && is_shift;
    assign o_dec.ch        = ch;

endmodule

`default_nettype wire

[rtl/scancode_to_char_fifo_unit.sv]
// top level: scan code decoder feeding a character fifo held in ram
//
//  channel   | handshake             | payload
//  ----------+-----------------------+---------------------------------
//  request   | start / busy          | i_req  (req_type, scan_code)
//  result    | o_strobe, one cycle   | o_res  (read_char, fifo_was_empty)
//
// a request is taken when start is high and busy is low; a scan code is decoded and written to the
// fifo ram in the cycle it is taken, so one item per cycle is sustained while busy is low.
// a read shows its result in the cycle after the transfer, as the ram's read port is
// registered; reads and scan codes may follow each other back to back.
// busy is high during reset and until the registered live flag is set after it; the fifo needs no clearing.
// the receiver cannot stall, so results are never held.
`default_nettype none

module scancode_to_char_fifo_unit
    import sc2c_pkg::*;
#(
    parameter int FIFO_DEPTH = 128
) (
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    input  wire logic start,
    output logic      busy,
    input  wire t_req i_req,
    output logic      o_strobe,
    output t_res      o_res
);

    localparam int AW    = $clog2(FIFO_DEPTH);
    localparam int CNT_W = $clog2(FIFO_DEPTH + 1);

    logic             r_live;
    logic             r_shift;
    logic [AW-1:0]    r_rd_idx, n_rd_idx;
    logic [AW-1:0]    r_wr_idx, n_wr_idx;
    logic [CNT_W-1:0] r_count, n_count;
    logic             r_strobe;
    logic             r_empty;

    logic       accept;
    logic       is_scan;
    logic       is_read;
    logic       fifo_full;
    logic       fifo_empty;
    logic       do_push;
    logic       do_pop;
    t_dec       dec;
    logic [7:0] ram_rdata;

    // transfer qualification
    assign busy       = !r_live;
    assign accept     = start && !busy;
    assign is_scan    = accept && (i_req.req_type == REQ_SCAN);
    assign is_read    = accept && (i_req.req_type == REQ_READ);
    assign fifo_full  = (r_count == CNT_W'(FIFO_DEPTH));
    assign fifo_empty = (r_count == '0);

    sc2c_decode u_decode (
        .i_scan_code  (i_req.scan_code),
        .i_shift_held (r_shift),
        .o_dec        (dec)
    );

    assign do_push = is_scan && dec.push && !fifo_full;
    assign do_pop  = is_read && !fifo_empty;

    sc2c_ram #(
        .WIDTH (8),
        .DEPTH (FIFO_DEPTH)
    ) u_char_ram (
        .i_clk   (i_clk),
        .i_we    (do_push),
        .i_waddr (r_wr_idx),
        .i_wdata (dec.ch),
        .i_re    (do_pop),
        .i_raddr (r_rd_idx),
        .o_rdata (ram_rdata)
    );

    // pointer and count updates with wrap at the fifo depth
    always_comb begin
        n_rd_idx = r_rd_idx;
        n_wr_idx = r_wr_idx;
        n_count  = r_count;
        if (do_pop) begin
            n_rd_idx = (r_rd_idx == AW'(FIFO_DEPTH - 1)) ? '0 : r_rd_idx + 1'b1;
        end
        if (do_push) begin
            n_wr_idx = (r_wr_idx == AW'(FIFO_DEPTH - 1)) ? '0 : r_wr_idx + 1'b1;
        end
        if (do_push && !do_pop) begin
            n_count = r_count + 1'b1;
        end else if (do_pop && !do_push) begin
            n_count = r_count - 1'b1;
        end
    end

    // control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_live   <= 1'b0;
            r_shift  <= 1'b0;
            r_rd_idx <= '0;
            r_wr_idx <= '0;
            r_count  <= '0;
            r_strobe <= 1'b0;
        end else begin
            r_live   <= 1'b1;
            r_rd_idx <= n_rd_idx;
            r_wr_idx <= n_wr_idx;
            r_count  <= n_count;
            r_strobe <= is_read;
            if (is_scan && dec.shift_set) begin
                r_shift <= 1'b1;
            end else if (is_scan && dec.shift_clr) begin
                r_shift <= 1'b0;
            end
        end
    end

    // empty flag travels with the read into the result cycle
    always_ff @(posedge i_clk) begin
        if (is_read) begin
            r_empty <= fifo_empty;
        end
    end

    // result drive
    assign o_strobe             = r_strobe;
    assign o_res.read_char      = r_empty ? 8'd0 : ram_rdata;
    assign o_res.fifo_was_empty = r_empty;

`ifndef SYNTH
    // count never passes the depth
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CNT_W'(FIFO_DEPTH))
        else $error("fifo count exceeds depth");

    // every read transfer gives a result in the next cycle
    a_strobe_src: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_live && is_read |=> o_strobe)
        else $error("read transfer without result");

    // an empty answer only when the fifo held nothing at the read
    a_empty_ok: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        is_read && r_count != '0 |=> !o_res.fifo_was_empty)
        else $error("empty answer with data held");

    // a full fifo stays full across a scan code transfer
    a_full_drop: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        is_scan && fifo_full |=> r_count == CNT_W'(FIFO_DEPTH))
        else $error("push into full fifo changed the count");
`endif

endmodule

`default_nettype wire

[verif/scancode_to_char_fifo_unit_test.sv]
// self-checking testbench for the scan code decoder with its character fifo
`timescale 1ns / 100ps

module scancode_to_char_fifo_unit_test
    import sc2c_pkg::*;
();

    localparam int FIFO_DEPTH = 128;
    localparam int RANDOM_ITEMS = 700;
    localparam int BURST_ITEMS = 200;
    localparam int DRAIN_CYCLES = 64;

    // set-1 make codes of interest
    localparam logic [7:0] KEY_A      = 8'h1E;
    localparam logic [7:0] KEY_Y      = 8'h2C;
    localparam logic [7:0] KEY_Z      = 8'h15;
    localparam logic [7:0] KEY_1      = 8'h02;
    localparam logic [7:0] KEY_SZ     = 8'h0C;
    localparam logic [7:0] KEY_UE     = 8'h1A;
    localparam logic [7:0] KEY_BS     = 8'h0E;
    localparam logic [7:0] KEY_TAB    = 8'h0F;
    localparam logic [7:0] KEY_ENTER  = 8'h1C;
    localparam logic [7:0] KEY_HASH   = 8'h2B;
    localparam logic [7:0] KEY_SPACE  = 8'h39;
    localparam logic [7:0] KEY_LSHIFT = 8'h2A;
    localparam logic [7:0] KEY_RSHIFT = 8'h36;
    localparam logic [7:0] BREAK_BIT  = 8'h80;

    // german layout for make codes 0x00..0x3f, higher codes are unmapped
    localparam logic [7:0] GERMAN_KEYS [0:63] = '{
        8'd0,  8'd0,  "1",   "2",   "3",   "4",   "5",   "6",
        "7",   "8",   "9",   "0",   8'hDF, 8'hB4, 8'd8,  8'd9,
        "q",   "w",   "e",   "r",   "t",   "z",   "u",   "i",
        "o",   "p",   8'hFC, "+",   8'd10, 8'd0,  "a",   "s",
        "d",   "f",   "g",   "h",   "j",   "k",   "l",   8'hF6,
        8'hE4, "^",   8'd15, "#",   "y",   "x",   "c",   "v",
        "b",   "n",   "m",   ",",   ".",   "-",   8'd15, 8'd0,
        8'd0,  " ",   8'd0,  8'd0,  8'd0,  8'd0,  8'd0,  8'd0
    };

    logic i_clk;
    logic i_rst_n;
    logic start;
    logic busy;
    t_req i_req;
    logic o_strobe;
    t_res o_res;

    // predictor state
    logic       shift_down;
    logic [7:0] typed_chars[$];
    t_res       due_results[$];

    // run statistics
    int fail_count;
    int item_count;
    int scan_count;
    int read_count;
    int empty_reads;
    int full_drops;
    int upper_count;
    bit pauses_on;

    scancode_to_char_fifo_unit #(
        .FIFO_DEPTH(FIFO_DEPTH)
    ) uut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .start   (start),
        .busy    (busy),
        .i_req   (i_req),
        .o_strobe(o_strobe),
        .o_res   (o_res)
    );

    // clock
    initial begin
        i_clk = 1'b0;
        forever #4 i_clk = ~i_clk;
    end

    // watchdog
    initial begin
        #3_000_000;
        $display("scancode_to_char_fifo_unit_test failed");
        $finish;
    end

    function automatic logic [7:0] layout_char(input logic [6:0] key);
        return key[6] ? 8'd0 : GERMAN_KEYS[key[5:0]];
    endfunction

    // decode one accepted request and update the expected fifo contents
    function automatic void apply_request(input t_req r);
        logic [7:0] ch;
        t_res       res;
        if (r.req_type == REQ_SCAN) begin
            scan_count++;
            ch = layout_char(r.scan_code[6:0]);
            if (r.scan_code[7]) begin
                // break code only matters for shift
                if (ch == SHIFT_MARK) shift_down = 1'b0;
            end else begin
                if (ch == SHIFT_MARK) shift_down = 1'b1;
                if (ch >= LOWER_A && ch <= LOWER_Z && shift_down) begin
                    ch = ch - CASE_GAP;
                    upper_count++;
                end
                if (ch >= PRINT_MIN || ch == CH_NL || ch == CH_BS) begin
                    if (typed_chars.size() < FIFO_DEPTH) typed_chars.push_back(ch);
                    else full_drops++;
                end
            end
        end else begin
            read_count++;
            if (typed_chars.size() == 0) begin
                res.read_char = 8'd0;
                res.fifo_was_empty = 1'b1;
                empty_reads++;
            end else begin
                res.read_char = typed_chars.pop_front();
                res.fifo_was_empty = 1'b0;
            end
            due_results.push_back(res);
        end
    endfunction

    task automatic report_mismatch(input string what, input int exp_val, input int got_val);
        $display("mismatch at %0t: %s expected %0h got %0h", $realtime, what, exp_val, got_val);
        fail_count++;
    endtask

    // random sender gap with start held low
    task automatic sender_pause();
        if (pauses_on && $urandom_range(0, 2) == 0) begin
            @(negedge i_clk);
            start <= 1'b0;
            repeat ($urandom_range(1, 18)) @(posedge i_clk);
        end
    endtask

    // one request transfer, predicted when accepted
    task automatic send_item(input logic kind, input logic [7:0] code);
        t_req r;
        r.req_type = kind;
        r.scan_code = code;
        @(negedge i_clk);
        start <= 1'b1;
        i_req <= r;
        @(posedge i_clk);
        while (busy !== 1'b0) @(posedge i_clk);
        apply_request(r);
        item_count++;
        sender_pause();
    endtask

    task automatic press(input logic [7:0] code);
        send_item(REQ_SCAN, code);
    endtask

    task automatic read_char_req();
        send_item(REQ_READ, 8'($urandom_range(0, 255)));
    endtask

    task automatic drain_fifo();
        while (typed_chars.size() > 0) read_char_req();
    endtask

    // result checker, compares after the sending process has updated the predictor
    always @(posedge i_clk) begin : result_check
        t_res got;
        t_res want;
        if (i_rst_n === 1'b1 && o_strobe === 1'b1) begin
            got = o_res;
            #1;
            if (due_results.size() == 0) begin
                report_mismatch("unexpected result, char", 0, got.read_char);
            end else begin
                want = due_results.pop_front();
                if (got.read_char !== want.read_char)
                    report_mismatch("read_char", want.read_char, got.read_char);
                if (got.fifo_was_empty !== want.fifo_was_empty)
                    report_mismatch("fifo_was_empty", want.fifo_was_empty, got.fifo_was_empty);
            end
        end
    end

    // empty reads, unmapped and extreme codes, shift handling and the filter
    task automatic test_directed();
        send_item(REQ_READ, 8'h00);
        send_item(REQ_READ, 8'hFF);
        press(8'h00);
        press(8'h7F);
        press(8'h80);
        press(8'hFF);
        press(KEY_A);
        press(KEY_LSHIFT);
        press(KEY_A);
        press(KEY_Y);
        press(KEY_1);
        press(KEY_UE);
        press(KEY_LSHIFT | BREAK_BIT);
        press(KEY_A);
        press(KEY_RSHIFT);
        press(KEY_Z);
        press(KEY_RSHIFT | BREAK_BIT);
        press(KEY_A | BREAK_BIT);
        press(KEY_ENTER);
        press(KEY_BS);
        press(KEY_TAB);
        press(KEY_SPACE);
        press(KEY_HASH);
        press(KEY_SZ);
        drain_fifo();
        read_char_req();
    endtask

    // overfill past the depth so characters drop, then read past empty
    task automatic test_fifo_full();
        drain_fifo();
        repeat (FIFO_DEPTH + 4) press(8'($urandom_range(8'h10, 8'h19)));
        repeat (FIFO_DEPTH + 2) read_char_req();
    endtask

    // mostly well-formed typing with shift, mixed with reads, noise and stray codes
    task automatic test_random_typing(input int n_items);
        int         stop_at;
        int         pick;
        logic [7:0] key;
        logic [7:0] shift_key;
        stop_at = item_count + n_items;
        while (item_count < stop_at) begin
            pick = $urandom_range(0, 99);
            if (pick < 55) begin
                shift_key = $urandom_range(0, 1) ? KEY_LSHIFT : KEY_RSHIFT;
                if ($urandom_range(0, 2) == 0) press(shift_key);
                repeat ($urandom_range(1, 3)) begin
                    key = 8'($urandom_range(1, 8'h39));
                    press(key);
                    if ($urandom_range(0, 3) != 0) press(key | BREAK_BIT);
                end
                if ($urandom_range(0, 1) == 0) press(shift_key | BREAK_BIT);
            end else if (pick < 82) begin
                repeat ($urandom_range(1, 4)) read_char_req();
            end else if (pick < 92) begin
                press(8'($urandom_range(0, 255)));
            end else begin
                // stray break code or a shift left held down
                if ($urandom_range(0, 1) == 0) press(8'($urandom_range(8'h80, 8'hFF)));
                else press($urandom_range(0, 1) ? KEY_LSHIFT : KEY_RSHIFT);
            end
        end
    endtask

    // back to back requests with no sender gaps
    task automatic test_back_to_back(input int n_items);
        int stop_at;
        pauses_on = 1'b0;
        stop_at = item_count + n_items;
        while (item_count < stop_at) begin
            if ($urandom_range(0, 1) == 0) press(8'($urandom_range(0, 255)));
            else read_char_req();
        end
        drain_fifo();
        read_char_req();
    endtask

    initial begin
        int waited;
        start = 1'b0;
        i_req = '0;
        i_rst_n = 1'b0;
        shift_down = 1'b0;
        fail_count = 0;
        item_count = 0;
        scan_count = 0;
        read_count = 0;
        empty_reads = 0;
        full_drops = 0;
        upper_count = 0;
        pauses_on = 1'b1;

        repeat (3) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        test_directed();
        test_fifo_full();
        test_random_typing(RANDOM_ITEMS);
        test_back_to_back(BURST_ITEMS);

        @(negedge i_clk);
        start <= 1'b0;
        waited = 0;
        while (due_results.size() > 0 && waited < DRAIN_CYCLES) begin
            @(posedge i_clk);
            waited++;
        end
        repeat (8) @(posedge i_clk);
        while (due_results.size() > 0) begin
            report_mismatch("missing result, char", due_results[0].read_char, 0);
            void'(due_results.pop_front());
        end

        $display("covered %0d requests: %0d scan codes, %0d reads (%0d on an empty fifo)",
                 item_count, scan_count, read_count, empty_reads);
        $display("%0d shifted letters, %0d characters dropped on a full fifo, %0d mismatches",
                 upper_count, full_drops, fail_count);
        if (fail_count == 0) begin
            $display("scancode_to_char_fifo_unit_test passed");
        end else begin
            $display("scancode_to_char_fifo_unit_test failed");
        end
        $finish;
    end

endmodule
